>>> rtl/ethp_pkg.sv
// shared types, constants and helper functions for the ethernet/ipv4/tcp header parser
// used by the field parser, the result queue and the top level
package ethp_pkg;

   // byte position counter width within a frame
   localparam int OFFSET_WIDTH = 16;

   // fixed header layout, in bytes from the start of the frame
   localparam int ETH_HDR_LEN   = 14;
   localparam int DEST_MAC_POS  = 0;
   localparam int SRC_MAC_POS   = 6;
   localparam int MAC_LEN       = 6;
   localparam int IP_LEN_POS    = ETH_HDR_LEN + 2;
   localparam int IP_LEN_LEN    = 2;
   localparam int SRC_IP_POS    = ETH_HDR_LEN + 12;
   localparam int DEST_IP_POS   = ETH_HDR_LEN + 16;
   localparam int WORD_LEN      = 4;
   localparam int TCP_SEQ_REL   = 4;
   localparam int TCP_ACK_REL   = 8;
   localparam int TCP_DOFF_REL  = 12;
   localparam int TCP_FLAGS_REL = 13;

   // header length words below this are taken as the legal minimum
   localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

   // tcp flag bit positions within the flags byte
   localparam int FLAG_ACK_BIT = 4;
   localparam int FLAG_RST_BIT = 2;
   localparam int FLAG_SYN_BIT = 1;

   // result kinds
   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // result queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef logic [OFFSET_WIDTH-1:0] offset_type;

   // result fields except kind, last declared field sits in the lowest bits
   typedef struct packed {
      logic [15:0] captured_length;
      logic [15:0] ip_data_length;
      logic [2:0]  flag_bits;
      logic [31:0] ack_number;
      logic [31:0] seq_number;
      logic [31:0] port_pair;
      logic [31:0] dest_ip;
      logic [31:0] source_ip;
      logic [47:0] source_mac;
      logic [47:0] dest_mac;
      logic [7:0]  data_byte;
   } rsp_body_type;

   localparam int BODY_WIDTH  = $bits(rsp_body_type);
   localparam int TDATA_WIDTH = ((BODY_WIDTH + 7) / 8) * 8;

   typedef struct packed {
      logic         kind;
      rsp_body_type body;
   } rsp_item_type;

   // up to two results produced by one accepted byte, in delivery order
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } parse_push_type;

   // true when off lies in [start, start + len)
   function automatic logic in_span(input offset_type off, input offset_type start,
                                    input logic [2:0] len);
      logic [OFFSET_WIDTH:0] stop;
      stop = {1'b0, start} + (OFFSET_WIDTH + 1)'(len);
      return ({1'b0, off} >= {1'b0, start}) && ({1'b0, off} < stop);
   endfunction

   // header length in words, floored at the legal minimum
   function automatic logic [3:0] at_least_five(input logic [3:0] words);
      return (words < MIN_HDR_WORDS) ? MIN_HDR_WORDS : words;
   endfunction

endpackage

>>> rtl/ethp_field_parser.sv
// per-byte header field capture and payload/summary result generation
// depends on ethp_pkg for layout constants, result types and helpers
module ethp_field_parser
   import ethp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  logic [7:0]     frame_byte,
   input  logic           frame_end,
   output parse_push_type push
);

   offset_type  byte_offset_ff, byte_offset_in;
   logic [47:0] dest_mac_ff, dest_mac_in;
   logic [47:0] source_mac_ff, source_mac_in;
   logic [31:0] source_ip_ff, source_ip_in;
   logic [31:0] dest_ip_ff, dest_ip_in;
   logic [31:0] port_ff, port_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] ack_ff, ack_in;
   logic [2:0]  flag_ff, flag_in;
   logic [3:0]  ip_words_ff, ip_words_in;
   logic [3:0]  tcp_words_ff, tcp_words_in;
   logic [15:0] ip_total_ff, ip_total_in;
   logic [15:0] data_count_ff, data_count_in;

   offset_type  tcp_start;
   offset_type  data_start;
   logic [3:0]  ip_words_min;
   logic [3:0]  tcp_words_min;
   logic [7:0]  hdr_bytes;
   logic [15:0] data_length;
   logic        emit_data;
   rsp_item_type data_item;
   rsp_item_type summary_item;

   // field capture and payload decision for the current byte
   always_comb begin
      dest_mac_in   = dest_mac_ff;
      source_mac_in = source_mac_ff;
      source_ip_in  = source_ip_ff;
      dest_ip_in    = dest_ip_ff;
      port_in       = port_ff;
      seq_in        = seq_ff;
      ack_in        = ack_ff;
      flag_in       = flag_ff;
      ip_total_in   = ip_total_ff;
      ip_words_in   = ip_words_ff;
      tcp_words_in  = tcp_words_ff;

      // ihl sits in the low nibble of the first ip byte
      if (byte_offset_ff == offset_type'(ETH_HDR_LEN)) begin
         ip_words_in = frame_byte[3:0];
      end
      ip_words_min = at_least_five(ip_words_in);
      tcp_start    = offset_type'(ETH_HDR_LEN) + offset_type'({ip_words_min, 2'b00});

      if (in_span(byte_offset_ff, offset_type'(DEST_MAC_POS), 3'(MAC_LEN))) begin
         dest_mac_in = {dest_mac_ff[39:0], frame_byte};
      end
      if (in_span(byte_offset_ff, offset_type'(SRC_MAC_POS), 3'(MAC_LEN))) begin
         source_mac_in = {source_mac_ff[39:0], frame_byte};
      end
      if (in_span(byte_offset_ff, offset_type'(IP_LEN_POS), 3'(IP_LEN_LEN))) begin
         ip_total_in = {ip_total_ff[7:0], frame_byte};
      end
      if (in_span(byte_offset_ff, offset_type'(SRC_IP_POS), 3'(WORD_LEN))) begin
         source_ip_in = {source_ip_ff[23:0], frame_byte};
      end
      if (in_span(byte_offset_ff, offset_type'(DEST_IP_POS), 3'(WORD_LEN))) begin
         dest_ip_in = {dest_ip_ff[23:0], frame_byte};
      end
      if (in_span(byte_offset_ff, tcp_start, 3'(WORD_LEN))) begin
         port_in = {port_ff[23:0], frame_byte};
      end
      if (in_span(byte_offset_ff, tcp_start + offset_type'(TCP_SEQ_REL), 3'(WORD_LEN))) begin
         seq_in = {seq_ff[23:0], frame_byte};
      end
      if (in_span(byte_offset_ff, tcp_start + offset_type'(TCP_ACK_REL), 3'(WORD_LEN))) begin
         ack_in = {ack_ff[23:0], frame_byte};
      end
      // data offset in the high nibble, then the flags byte
      if (byte_offset_ff == tcp_start + offset_type'(TCP_DOFF_REL)) begin
         tcp_words_in = frame_byte[7:4];
      end
      if (byte_offset_ff == tcp_start + offset_type'(TCP_FLAGS_REL)) begin
         flag_in = {frame_byte[FLAG_ACK_BIT], frame_byte[FLAG_RST_BIT],
                    frame_byte[FLAG_SYN_BIT]};
      end

      // payload start and length implied by the ip total length
      tcp_words_min = at_least_five(tcp_words_in);
      data_start    = tcp_start + offset_type'({tcp_words_min, 2'b00});
      hdr_bytes     = {2'b00, ip_words_min, 2'b00} + {2'b00, tcp_words_min, 2'b00};
      data_length   = (ip_total_in > {8'd0, hdr_bytes}) ?
                      (ip_total_in - {8'd0, hdr_bytes}) : 16'd0;

      emit_data     = (byte_offset_ff >= data_start) && (data_count_ff < data_length);
      data_count_in = data_count_ff + {15'd0, emit_data};

      // next offset saturates at the top of the counter
      byte_offset_in = (byte_offset_ff != '1) ? (byte_offset_ff + offset_type'(1))
                                               : byte_offset_ff;
   end

   // result items
   always_comb begin
      data_item                = '0;
      data_item.kind           = KIND_DATA;
      data_item.body.data_byte = frame_byte;

      summary_item                      = '0;
      summary_item.kind                 = KIND_SUMMARY;
      summary_item.body.dest_mac        = dest_mac_in;
      summary_item.body.source_mac      = source_mac_in;
      summary_item.body.source_ip       = source_ip_in;
      summary_item.body.dest_ip         = dest_ip_in;
      summary_item.body.port_pair       = port_in;
      summary_item.body.seq_number      = seq_in;
      summary_item.body.ack_number      = ack_in;
      summary_item.body.flag_bits       = flag_in;
      summary_item.body.ip_data_length  = data_length;
      summary_item.body.captured_length = data_count_in;

      push.count  = fire ? (2'(emit_data) + 2'(frame_end)) : 2'd0;
      push.first  = emit_data ? data_item : summary_item;
      push.second = summary_item;
   end

   // frame state, cleared at reset and after every summary
   always_ff @(posedge clock) begin
      if (reset || (fire && frame_end)) begin
         byte_offset_ff <= '0;
         dest_mac_ff    <= '0;
         source_mac_ff  <= '0;
         source_ip_ff   <= '0;
         dest_ip_ff     <= '0;
         port_ff        <= '0;
         seq_ff         <= '0;
         ack_ff         <= '0;
         flag_ff        <= '0;
         ip_words_ff    <= '0;
         tcp_words_ff   <= '0;
         ip_total_ff    <= '0;
         data_count_ff  <= '0;
      end else if (fire) begin
         byte_offset_ff <= byte_offset_in;
         dest_mac_ff    <= dest_mac_in;
         source_mac_ff  <= source_mac_in;
         source_ip_ff   <= source_ip_in;
         dest_ip_ff     <= dest_ip_in;
         port_ff        <= port_in;
         seq_ff         <= seq_in;
         ack_ff         <= ack_in;
         flag_ff        <= flag_in;
         ip_words_ff    <= ip_words_in;
         tcp_words_ff   <= tcp_words_in;
         ip_total_ff    <= ip_total_in;
         data_count_ff  <= data_count_in;
      end
   end

endmodule

>>> rtl/ethp_result_queue.sv
// small result queue that takes up to two results per cycle and delivers one per cycle while out_ready is high
// depends on ethp_pkg for the result item types and queue sizing
module ethp_result_queue
   import ethp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  parse_push_type        push,
   output logic                  has_room,
   output logic [QCNT_WIDTH-1:0] level,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rsp_item_type          out_item
);

   rsp_item_type mem [QUEUE_DEPTH];

   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;
   logic [QPTR_WIDTH-1:0] wr_next;
   logic                  pop;

   assign wr_next   = wr_ptr_ff + QPTR_WIDTH'(1);
   assign out_valid = (count_ff != '0);
   assign out_item  = mem[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign has_room  = (count_ff <= QCNT_WIDTH'(QUEUE_DEPTH - 2));
   assign level     = count_ff;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_WIDTH'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_WIDTH'(pop);
      count_in  = count_ff + QCNT_WIDTH'(push.count) - QCNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage writes, in order
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.second;
      end
   end

endmodule

>>> rtl/eth_ipv4_tcp_header_parser.sv
// top level of the ethernet/ipv4/tcp header parser
// depends on ethp_pkg, ethp_field_parser and ethp_result_queue
//
// Usage:
//   The req channel carries a captured frame one byte per word in wire
//   order, starting at the ethernet header, with req_tlast on the final
//   captured byte. The rsp channel returns each tcp payload byte
//   (rsp_tuser low) while the count stays under the ip-indicated payload
//   length, and on the final byte a header summary word (rsp_tuser high)
//   that is always the last word of the frame.
//   Each result is written into the result queue and offered from there.
//   Throughput: one byte per cycle while req_tready is high; a final byte
//   that also carries payload yields two words, delivered in order.
//   req_tready is set by the fill of a four-word result queue: it stays
//   high while the queue can still take two words, so a byte is taken
//   while earlier results wait. When the receiver stalls the queue fills
//   and req_tready drops until words drain.
//   Reset clears the frame position, all captured fields and the queue;
//   the block then waits for the first byte of a new frame.
module eth_ipv4_tcp_header_parser
   import ethp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input bytes
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // frame_byte
   input  logic                   req_tlast,   // frame_end
   // results
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // data_byte, dest_mac, source_mac, source_ip, dest_ip, port_pair,
   // seq_number, ack_number, flag_bits, ip_data_length, captured_length, zero fill
   output logic [TDATA_WIDTH-1:0] rsp_tdata,
   output logic                   rsp_tuser    // kind
);

   logic                  req_fire;
   parse_push_type        push;
   rsp_item_type          head_item;
   logic [QCNT_WIDTH-1:0] queue_level;

   assign req_fire = req_tvalid && req_tready;

   // field capture for each accepted byte
   ethp_field_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .fire       (req_fire),
      .frame_byte (req_tdata),
      .frame_end  (req_tlast),
      .push       (push)
   );

   // result buffering toward the receiver
   ethp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (req_tready),
      .level     (queue_level),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head_item)
   );

   // result packing
   assign rsp_tdata = {(TDATA_WIDTH - BODY_WIDTH)'(0), head_item.body};
   assign rsp_tuser = head_item.kind;

   // two results from one byte only on a final byte, payload first then summary
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |->
         (req_tlast && push.first.kind == KIND_DATA && push.second.kind == KIND_SUMMARY))
      else $error("two results pushed out of order or not on a final byte");

   // a final byte always yields a summary as its last pushed result
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |->
         ((push.count == 2'd1 && push.first.kind == KIND_SUMMARY) ||
          (push.count == 2'd2)))
      else $error("final byte did not produce a summary");

   // a summary never reports more payload bytes than the ip length allows
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0 && push.second.kind == KIND_SUMMARY && req_tlast) |->
         (push.second.body.captured_length <= push.second.body.ip_data_length))
      else $error("captured length exceeds ip data length");

   // the queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_level <= QCNT_WIDTH'(QUEUE_DEPTH))
      else $error("result queue overflow");

endmodule

>>> sim/ethp_checker.sv
// checker for the ethernet/ipv4/tcp header parser: predicts result words from accepted bytes
// depends on ethp_pkg for the result layout, header positions and kind codes
module ethp_checker
   import ethp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [TDATA_WIDTH-1:0] rsp_tdata,
   input  logic                   rsp_tuser,
   output int                     error_count,
   output int                     pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   // predicted words not yet seen on the rsp channel, oldest first
   rsp_item_type expected_words[$];

   // captured frame state of the predictor
   logic [15:0] frame_pos;
   logic [47:0] dmac_acc;
   logic [47:0] smac_acc;
   logic [31:0] sip_acc;
   logic [31:0] dip_acc;
   logic [31:0] port_acc;
   logic [31:0] seq_acc;
   logic [31:0] ack_acc;
   logic [2:0]  flag_acc;
   logic [3:0]  ihl_words;
   logic [3:0]  doff_words;
   logic [15:0] ip_len_acc;
   logic [15:0] payload_sent;

   function automatic int hdr_words(input logic [3:0] words);
      return (words < MIN_HDR_WORDS) ? int'(MIN_HDR_WORDS) : int'(words);
   endfunction

   task automatic clear_frame();
      frame_pos    = '0;
      dmac_acc     = '0;
      smac_acc     = '0;
      sip_acc      = '0;
      dip_acc      = '0;
      port_acc     = '0;
      seq_acc      = '0;
      ack_acc      = '0;
      flag_acc     = '0;
      ihl_words    = '0;
      doff_words   = '0;
      ip_len_acc   = '0;
      payload_sent = '0;
   endtask

   // one accepted frame byte: update captured fields and queue what it yields
   task automatic predict_byte(input logic [7:0] b, input logic last);
      int off;
      int tcp_at;
      int data_at;
      int hdr_len;
      int data_len;
      rsp_item_type word;
      off = int'(frame_pos);
      if (off == ETH_HDR_LEN) ihl_words = b[3:0];
      tcp_at = ETH_HDR_LEN + hdr_words(ihl_words) * WORD_LEN;

      if (off >= DEST_MAC_POS && off < DEST_MAC_POS + MAC_LEN) dmac_acc = {dmac_acc[39:0], b};
      if (off >= SRC_MAC_POS && off < SRC_MAC_POS + MAC_LEN) smac_acc = {smac_acc[39:0], b};
      if (off >= IP_LEN_POS && off < IP_LEN_POS + IP_LEN_LEN) ip_len_acc = {ip_len_acc[7:0], b};
      if (off >= SRC_IP_POS && off < SRC_IP_POS + WORD_LEN) sip_acc = {sip_acc[23:0], b};
      if (off >= DEST_IP_POS && off < DEST_IP_POS + WORD_LEN) dip_acc = {dip_acc[23:0], b};
      if (off >= tcp_at && off < tcp_at + WORD_LEN) port_acc = {port_acc[23:0], b};
      if (off >= tcp_at + TCP_SEQ_REL && off < tcp_at + TCP_SEQ_REL + WORD_LEN)
         seq_acc = {seq_acc[23:0], b};
      if (off >= tcp_at + TCP_ACK_REL && off < tcp_at + TCP_ACK_REL + WORD_LEN)
         ack_acc = {ack_acc[23:0], b};
      if (off == tcp_at + TCP_DOFF_REL) doff_words = b[7:4];
      if (off == tcp_at + TCP_FLAGS_REL)
         flag_acc = {b[FLAG_ACK_BIT], b[FLAG_RST_BIT], b[FLAG_SYN_BIT]};

      // payload window, trimmed by the ip length, which saturates at zero
      data_at  = tcp_at + hdr_words(doff_words) * WORD_LEN;
      hdr_len  = (hdr_words(ihl_words) + hdr_words(doff_words)) * WORD_LEN;
      data_len = (int'(ip_len_acc) > hdr_len) ? int'(ip_len_acc) - hdr_len : 0;
      if (off >= data_at && int'(payload_sent) < data_len) begin
         word = '0;
         word.kind = KIND_DATA;
         word.body.data_byte = b;
         expected_words.push_back(word);
         payload_sent = payload_sent + 16'd1;
      end

      // frame position holds at its maximum on very long frames
      if (frame_pos != '1) frame_pos = frame_pos + 16'd1;

      // summary always closes the frame
      if (last) begin
         word = '0;
         word.kind = KIND_SUMMARY;
         word.body.dest_mac        = dmac_acc;
         word.body.source_mac      = smac_acc;
         word.body.source_ip       = sip_acc;
         word.body.dest_ip         = dip_acc;
         word.body.port_pair       = port_acc;
         word.body.seq_number      = seq_acc;
         word.body.ack_number      = ack_acc;
         word.body.flag_bits       = flag_acc;
         word.body.ip_data_length  = 16'(data_len);
         word.body.captured_length = payload_sent;
         expected_words.push_back(word);
         clear_frame();
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // compare one accepted rsp word against the oldest prediction
   task automatic check_word();
      rsp_item_type want;
      rsp_body_type got;
      if (expected_words.size() == 0) begin
         error_count++;
         $display("%0t: word with nothing expected, expected none, got kind %0b data %0h",
                  $time, rsp_tuser, rsp_tdata);
      end else begin
         want = expected_words.pop_front();
         got  = rsp_tdata[BODY_WIDTH-1:0];
         check_field("kind", 64'(want.kind), 64'(rsp_tuser));
         check_field("data_byte", 64'(want.body.data_byte), 64'(got.data_byte));
         check_field("dest_mac", 64'(want.body.dest_mac), 64'(got.dest_mac));
         check_field("source_mac", 64'(want.body.source_mac), 64'(got.source_mac));
         check_field("source_ip", 64'(want.body.source_ip), 64'(got.source_ip));
         check_field("dest_ip", 64'(want.body.dest_ip), 64'(got.dest_ip));
         check_field("port_pair", 64'(want.body.port_pair), 64'(got.port_pair));
         check_field("seq_number", 64'(want.body.seq_number), 64'(got.seq_number));
         check_field("ack_number", 64'(want.body.ack_number), 64'(got.ack_number));
         check_field("flag_bits", 64'(want.body.flag_bits), 64'(got.flag_bits));
         check_field("ip_data_length", 64'(want.body.ip_data_length),
                     64'(got.ip_data_length));
         check_field("captured_length", 64'(want.body.captured_length),
                     64'(got.captured_length));
         check_field("zero fill", 64'd0, 64'(rsp_tdata[TDATA_WIDTH-1:BODY_WIDTH]));
      end
   endtask

   // results first: a word accepted now was caused by an earlier byte
   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         expected_words.delete();
         error_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_word();
         if (req_tvalid && req_tready) predict_byte(req_tdata, req_tlast);
      end
      pending_words = expected_words.size();
   end

endmodule

>>> sim/eth_ipv4_tcp_header_parser_tb.sv
// testbench top for the ethernet/ipv4/tcp header parser: frame stimulus, flow control, verdict
// depends on ethp_pkg, the parser rtl and ethp_checker
module eth_ipv4_tcp_header_parser_tb;
   import ethp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int RSP_HOLD          = 200;
   localparam int TOTAL_BYTES       = 750;
   localparam int MIN_RANDOM_FRAMES = 3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TDATA_WIDTH-1:0] rsp_tdata;
   logic                   rsp_tuser;

   int   error_count;
   int   pending_words;
   int   quiet_cycles = 0;
   int   bytes_sent = 0;
   logic hold_ask = 1'b0;
   logic hold_on = 1'b0;

   // bytes of the frame being built
   logic [7:0] frame_bytes[$];

   eth_ipv4_tcp_header_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ethp_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .pending_words (pending_words)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] field_byte(input int fill);
      return (fill < 0) ? 8'($urandom) : 8'(fill);
   endfunction

   // frame with ethernet, ipv4 and tcp headers; total_len below zero means consistent
   task automatic build_frame(input int ihl, input int doff, input int pay_len,
                              input int total_len, input int pad_len, input int fill);
      int ihl_eff;
      int doff_eff;
      int ip_len;
      logic [7:0] nib;
      ihl_eff  = (ihl < 5) ? 5 : ihl;
      doff_eff = (doff < 5) ? 5 : doff;
      ip_len   = (total_len < 0) ? (ihl_eff + doff_eff) * 4 + pay_len : total_len;
      frame_bytes.delete();
      repeat (14) frame_bytes.push_back(field_byte(fill));
      frame_bytes.push_back({4'h4, ihl[3:0]});
      frame_bytes.push_back(field_byte(fill));
      frame_bytes.push_back(ip_len[15:8]);
      frame_bytes.push_back(ip_len[7:0]);
      repeat (16) frame_bytes.push_back(field_byte(fill));
      repeat ((ihl_eff - 5) * 4) frame_bytes.push_back(field_byte(fill));
      repeat (12) frame_bytes.push_back(field_byte(fill));
      nib = field_byte(fill);
      frame_bytes.push_back({doff[3:0], nib[3:0]});
      repeat (7) frame_bytes.push_back(field_byte(fill));
      repeat ((doff_eff - 5) * 4) frame_bytes.push_back(field_byte(fill));
      repeat (pay_len) frame_bytes.push_back(field_byte(fill));
      repeat (pad_len) frame_bytes.push_back(8'($urandom));
   endtask

   task automatic cut_frame(input int keep);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
   endtask

   // offer one byte, then hold it until accepted
   task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input bit steady);
      for (int i = 0; i < frame_bytes.size(); i++)
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1, steady ? 0 : pick_gap());
   endtask

   // stop offering until every predicted word has arrived
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
      @(posedge clock);
   endtask

   // result side flow control, with one long hold-off on request
   initial begin
      bit hold_taken;
      int gap;
      hold_taken = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_ask && !hold_taken) begin
            hold_taken = 1'b1;
            hold_on    <= 1'b1;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD) @(posedge clock);
            hold_on    <= 1'b0;
         end
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clock);
         else repeat ($urandom_range(1, 24)) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("eth_ipv4_tcp_header_parser_tb failed");
         $finish;
      end
   end

   initial begin
      int frame_no;
      int ihl;
      int doff;
      int pay;
      int total;
      int pick;
      int cut_lens[3];
      cut_lens = '{9, 28, 47};
      while (reset) @(posedge clock);
      @(posedge clock);

      // directed: all-ones fields with the longest headers
      build_frame(15, 15, 4, -1, 0, 8'hFF);
      send_frame(1'b0);
      // all-zero fields, footer trimmed by ip length
      build_frame(5, 5, 3, -1, 4, 8'h00);
      send_frame(1'b0);
      // payload on the final byte: data word then summary
      build_frame(5, 5, 4, -1, 0, -1);
      send_frame(1'b1);
      // single byte frame and truncated frames
      build_frame(5, 5, 0, -1, 0, -1);
      cut_frame(1);
      send_frame(1'b0);
      foreach (cut_lens[k]) begin
         build_frame(5, 5, 6, -1, 0, -1);
         cut_frame(cut_lens[k]);
         send_frame(1'b0);
      end
      // short header lengths taken as the minimum
      build_frame(0, 3, 4, -1, 2, -1);
      send_frame(1'b0);
      // ip length shorter than the headers
      build_frame(5, 5, 2, 10, 0, -1);
      send_frame(1'b0);
      // options, ip length longer than the capture
      build_frame(6, 7, 5, 160, 0, -1);
      send_frame(1'b0);
      wait_for_results();

      // random frames, mostly well formed
      frame_no = 0;
      while (bytes_sent < TOTAL_BYTES || frame_no < MIN_RANDOM_FRAMES) begin
         pick = $urandom_range(0, 99);
         ihl  = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 15) : 5;
         doff = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 15) : 5;
         pay  = $urandom_range(0, 40);
         if (frame_no == 0) begin
            // receiver holds off while a long frame keeps coming
            hold_ask <= 1'b1;
            wait (hold_on);
            build_frame(5, 5, 40, -1, 4, -1);
            send_frame(1'b1);
         end else if (pick < 60) begin
            total = -1;
            if ($urandom_range(0, 9) == 0)
               total = (ihl + doff) * 4 + pay + $urandom_range(1, 20);
            build_frame(ihl, doff, pay, total,
                        ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0, -1);
            send_frame($urandom_range(0, 3) == 0);
         end else if (pick < 75) begin
            build_frame(ihl, doff, pay, -1, 0, -1);
            cut_frame($urandom_range(1, frame_bytes.size()));
            send_frame(1'b0);
         end else if (pick < 90) begin
            build_frame($urandom_range(0, 15), $urandom_range(0, 15), pay,
                        $urandom_range(0, 65535), $urandom_range(0, 4), -1);
            send_frame(1'b0);
         end else begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 70)) frame_bytes.push_back(8'($urandom));
            send_frame(1'b0);
         end
         if (frame_no == 1 || $urandom_range(0, 9) == 0) wait_for_results();
         frame_no++;
      end

      wait_for_results();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("eth_ipv4_tcp_header_parser_tb passed");
      else
         $display("eth_ipv4_tcp_header_parser_tb failed");
      $finish;
   end

endmodule

>>> files.f
rtl/ethp_pkg.sv
rtl/ethp_field_parser.sv
rtl/ethp_result_queue.sv
rtl/eth_ipv4_tcp_header_parser.sv
sim/ethp_checker.sv
sim/eth_ipv4_tcp_header_parser_tb.sv
